FILE: rtl/core/cap_pkg.sv
// cap_pkg: constants and the arctangent table for the circle arc point generator
// used by circle_arc_point_generator; no other dependencies
package cap_pkg;

    localparam int DEF_MAX_POINTS   = 64;
    localparam int DEF_CORDIC_STEPS = 24;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 7;
    localparam int SPAN_W  = 16;
    localparam int ANGLE_W = 32;

    // one full turn in 1/128 degree
    localparam logic [SPAN_W-1:0] FULL_SPAN = 16'd46080;

    // cordic gain folded into the start vector, q2.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    // round(atan(2^-k) * 2^32 / (2*pi))
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] k);
        logic [ANGLE_W-1:0] v;
        case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/circle_arc_point_generator.sv
// circle_arc_point_generator: emits evenly spaced points along a circular arc
// one shared cordic rotator, one bit-serial divider and one multiplier under a sequencer
// depends on cap_pkg
//
// usage
//   input channel (i_in_valid / o_in_stall) takes one request beat: centre, radius,
//   point count and arc span. o_in_stall is high from acceptance until the last
//   point of the request has been taken, so one request is in work at a time.
//   output channel (o_out_valid / i_out_stall) gives one beat per point, o_last
//   marks the final one. a request with zero points gives no beats.
// timing
//   the step angle comes from a restoring divider, one quotient bit a cycle, once
//   per request (skipped for a single point on a partial arc).
//   each point has a load state, CORDIC_STEPS rotation steps on the shared
//   shift/add unit, multiply and add states for scale and offset of x and y, and
//   an output state that presents the beat.
// reset and stall
//   synchronous active-low reset returns the sequencer to idle; any request in
//   work is dropped and o_in_stall stays high while reset is held.
//   while i_out_stall is high the point beat is held unchanged.
module circle_arc_point_generator #(
    parameter int MAX_POINTS   = cap_pkg::DEF_MAX_POINTS,
    parameter int CORDIC_STEPS = cap_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [cap_pkg::COORD_W-1:0]   i_center_x,
    input  logic signed [cap_pkg::COORD_W-1:0]   i_center_y,
    input  logic        [cap_pkg::COORD_W-1:0]   i_radius,
    input  logic        [cap_pkg::COUNT_W-1:0]   i_num_points,
    input  logic        [cap_pkg::SPAN_W-1:0]    i_arc_angle,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cap_pkg::COORD_W-1:0]   o_point_x,
    output logic signed [cap_pkg::COORD_W-1:0]   o_point_y,
    output logic                                 o_last
);
    import cap_pkg::*;

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int DVW   = SPAN_W + CW;
    localparam int RMW   = DVW + 1;
    localparam int NUMW  = SPAN_W + ANGLE_W;
    localparam int ITW   = $clog2(NUMW);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_INIT = 9'b000000100,
        S_ROT  = 9'b000001000,
        S_MULX = 9'b000010000,
        S_ADDX = 9'b000100000,
        S_MULY = 9'b001000000,
        S_ADDY = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;

    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic        [COORD_W-1:0] r_rad;
    logic        [CW-1:0]      r_count;
    logic        [CW-1:0]      r_cnt;
    logic        [ANGLE_W-1:0] r_step;
    logic        [ANGLE_W-1:0] r_accum;
    logic        [DVW-1:0]     r_div;
    logic        [RMW-1:0]     r_rem;
    logic        [NUMW-1:0]    r_num;
    logic        [ITW-1:0]     r_iter;
    logic signed [33:0]        r_x;
    logic signed [33:0]        r_y;
    logic signed [32:0]        r_z;
    logic        [1:0]         r_quad;
    logic signed [64:0]        r_prod;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic                      r_last;

    // request capture
    logic [CW-1:0]  w_n;
    logic [CW-1:0]  w_d;
    always_comb begin
        if (i_num_points > COUNT_W'(MAX_POINTS)) begin
            w_n = CW'(MAX_POINTS);
        end else begin
            w_n = CW'(i_num_points);
        end
        if (i_arc_angle == FULL_SPAN) begin
            w_d = w_n;
        end else begin
            w_d = w_n - CW'(1);
        end
    end

    // divider step
    logic [RMW-1:0] w_rem_sh;
    logic           w_qbit;
    logic [RMW-1:0] w_rem_nx;
    always_comb begin
        w_rem_sh = {r_rem[RMW-2:0], r_num[NUMW-1]};
        w_qbit   = (w_rem_sh >= {1'b0, r_div});
        w_rem_nx = w_qbit ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
    end

    // cordic rotation step
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;
    logic signed [32:0] w_at;
    always_comb begin
        w_xs = r_x >>> r_iter[4:0];
        w_ys = r_y >>> r_iter[4:0];
        w_at = $signed({1'b0, atan_entry(r_iter[4:0])});
    end

    // quadrant fold and shared multiplier
    logic signed [33:0] w_s;
    logic signed [33:0] w_c;
    logic signed [31:0] w_op;
    logic signed [64:0] w_prod;
    always_comb begin
        case (r_quad)
            2'd0: begin
                w_s = r_y;
                w_c = r_x;
            end
            2'd1: begin
                w_s = r_x;
                w_c = -r_y;
            end
            2'd2: begin
                w_s = -r_y;
                w_c = -r_x;
            end
            default: begin
                w_s = -r_x;
                w_c = r_y;
            end
        endcase
        w_op   = (r_state == S_MULX) ? w_s[31:0] : w_c[31:0];
        w_prod = $signed({1'b0, r_rad}) * w_op;
    end

    // round, offset and saturate
    logic signed [64:0] w_round;
    logic signed [34:0] w_scaled;
    logic signed [35:0] w_sum;
    logic signed [31:0] w_cen;
    logic signed [31:0] w_sat;
    always_comb begin
        w_cen    = (r_state == S_ADDX) ? r_cx : r_cy;
        w_round  = r_prod + 65'sh20000000;
        w_scaled = w_round[64:30];
        w_sum    = {w_scaled[34], w_scaled} + {{4{w_cen[31]}}, w_cen};
        if (w_sum > 36'sh07FFFFFFF) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_sum < -36'sh080000000) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_count <= '0;
            r_iter  <= '0;
            r_step  <= '0;
            r_accum <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cx    <= i_center_x;
                        r_cy    <= i_center_y;
                        r_rad   <= i_radius;
                        r_count <= w_n;
                        r_cnt   <= '0;
                        r_accum <= '0;
                        r_div   <= DVW'(32'(FULL_SPAN) * 32'(w_d));
                        r_rem   <= '0;
                        r_num   <= {i_arc_angle, {ANGLE_W{1'b0}}};
                        r_iter  <= '0;
                        if (w_n == '0) begin
                            r_state <= S_IDLE;
                        end else if (w_d == '0) begin
                            r_step  <= '0;
                            r_state <= S_INIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_rem_nx;
                    r_num  <= {r_num[NUMW-2:0], w_qbit};
                    r_iter <= r_iter + ITW'(1);
                    if (r_iter == ITW'(NUMW - 1)) begin
                        r_step  <= {r_num[ANGLE_W-2:0], w_qbit};
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_x     <= CORDIC_X0;
                    r_y     <= '0;
                    r_z     <= $signed({3'b000, r_accum[29:0]});
                    r_quad  <= r_accum[31:30];
                    r_iter  <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[32]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    r_iter <= r_iter + ITW'(1);
                    if (r_iter == ITW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_prod  <= w_prod;
                    r_state <= S_ADDX;
                end
                S_ADDX: begin
                    r_px    <= w_sat;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_prod  <= w_prod;
                    r_state <= S_ADDY;
                end
                S_ADDY: begin
                    r_py    <= w_sat;
                    r_last  <= (r_cnt == r_count - CW'(1));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_accum <= r_accum + r_step;
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= r_last ? S_IDLE : S_INIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = (r_state == S_OUT);
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_last      = r_last;

endmodule

FILE: sim/circle_arc_point_generator_check.sv
// circle_arc_point_generator_check: watches both channels of the arc point generator,
// predicts every point beat with its own cordic and scaling, and counts mismatches
// depends on cap_pkg for widths and the full-turn span
module circle_arc_point_generator_check #(
    parameter int MAX_POINTS   = cap_pkg::DEF_MAX_POINTS,
    parameter int CORDIC_STEPS = cap_pkg::DEF_CORDIC_STEPS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [cap_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [cap_pkg::COORD_W-1:0] i_center_y,
    input  logic        [cap_pkg::COORD_W-1:0] i_radius,
    input  logic        [cap_pkg::COUNT_W-1:0] i_num_points,
    input  logic        [cap_pkg::SPAN_W-1:0]  i_arc_angle,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [cap_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [cap_pkg::COORD_W-1:0] i_point_y,
    input  logic                               i_last,
    output int                                 o_mismatches,
    output int                                 o_outstanding,
    output int                                 o_requests,
    output int                                 o_points,
    output int                                 o_empty_requests,
    output int                                 o_clamped_requests,
    output int                                 o_full_circles
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 60;
    localparam longint GAIN_START = 64'sd652032874;
    localparam longint HALF_LSB   = 64'sd536870912;

    // atan(2^-k) in binary angle units, index 0 first
    localparam logic [0:31][31:0] ARCTAN_TURNS = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} t_quadrant;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } t_arc_point;

    t_arc_point pending_points[$];

    initial begin
        o_mismatches       = 0;
        o_outstanding      = 0;
        o_requests         = 0;
        o_points           = 0;
        o_empty_requests   = 0;
        o_clamped_requests = 0;
        o_full_circles     = 0;
    end

    // sine and cosine in q2.30 of a binary angle
    task automatic sin_cos(input logic [31:0] phase, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = GAIN_START;
        y = 0;
        z = longint'({34'd0, phase[29:0]});
        for (int k = 0; k < CORDIC_STEPS && k < 32; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, ARCTAN_TURNS[k]});
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, ARCTAN_TURNS[k]});
            end
        end
        case (t_quadrant'(phase[31:30]))
            QUAD_I: begin
                s = y;
                c = x;
            end
            QUAD_II: begin
                s = x;
                c = -y;
            end
            QUAD_III: begin
                s = -y;
                c = -x;
            end
            default: begin
                s = -x;
                c = y;
            end
        endcase
    endtask

    // centre plus radius times trig value, rounded and clamped to 32 bits
    function automatic logic signed [31:0] offset_coord(input logic signed [31:0] centre,
                                                        input logic [31:0] r,
                                                        input longint t);
        longint prod;
        longint sum;
        prod = longint'({32'd0, r}) * t;
        sum  = longint'(centre) + ((prod + HALF_LSB) >>> 30);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    task automatic plot_arc(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [31:0] r, input logic [6:0] n_req,
                            input logic [15:0] span);
        logic [6:0]        n;
        logic [63:0]       divisor;
        logic [63:0]       quotient;
        logic [31:0]       step;
        logic [31:0]       phase;
        longint            s;
        longint            c;
        t_arc_point        pt;
        o_requests++;
        if (span == cap_pkg::FULL_SPAN)
            o_full_circles++;
        n = n_req;
        if (n_req > MAX_POINTS) begin
            n = 7'(MAX_POINTS);
            o_clamped_requests++;
        end
        if (n == 0) begin
            o_empty_requests++;
            return;
        end
        divisor = (span == cap_pkg::FULL_SPAN) ? 64'(n) : 64'(n) - 64'd1;
        if (divisor == 0) begin
            step = 32'd0;
        end else begin
            quotient = {16'd0, span, 32'd0} / (64'(cap_pkg::FULL_SPAN) * divisor);
            step = quotient[31:0];
        end
        phase = 32'd0;
        for (int i = 0; i < n; i++) begin
            sin_cos(phase, s, c);
            pt.x    = offset_coord(cx, r, s);
            pt.y    = offset_coord(cy, r, c);
            pt.last = (i == n - 1);
            pending_points = {pending_points, pt};
            phase = phase + step;
        end
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        o_mismatches++;
        if (o_mismatches <= REPORT_LIMIT)
            $display("%0t ns: point %0d %s expected %h got %h", $time, o_points, what, want, got);
        if (o_mismatches == REPORT_LIMIT)
            $display("%0t ns: further mismatches counted without report", $time);
    endtask

    always @(posedge i_clk) begin : watch
        t_arc_point want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_points.size() == 0) begin
                    report("beat with none expected, x", 32'hx, i_point_x);
                end else begin
                    want = pending_points.pop_front();
                    if (want.x !== i_point_x)
                        report("x", want.x, i_point_x);
                    if (want.y !== i_point_y)
                        report("y", want.y, i_point_y);
                    if (want.last !== i_last)
                        report("last", {31'd0, want.last}, {31'd0, i_last});
                end
                o_points++;
            end
            if (i_in_valid && !i_in_stall)
                plot_arc(i_center_x, i_center_y, i_radius, i_num_points, i_arc_angle);
            o_outstanding = pending_points.size();
        end
    end

endmodule

FILE: sim/circle_arc_point_generator_test.sv
// circle_arc_point_generator_test: drives arc requests into the point generator under
// three sender/receiver idle mixes and gives the verdict from the checker's count
// depends on cap_pkg, circle_arc_point_generator and circle_arc_point_generator_check
module circle_arc_point_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 335;
    localparam int QUIET_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 200;

    logic                               i_clk;
    logic                               rst_n      = 1'b0;
    logic                               in_valid   = 1'b0;
    logic signed [cap_pkg::COORD_W-1:0] center_x   = '0;
    logic signed [cap_pkg::COORD_W-1:0] center_y   = '0;
    logic        [cap_pkg::COORD_W-1:0] radius     = '0;
    logic        [cap_pkg::COUNT_W-1:0] num_points = '0;
    logic        [cap_pkg::SPAN_W-1:0]  arc_angle  = '0;
    logic                               out_stall  = 1'b0;
    logic                               in_stall;
    logic                               out_valid;
    logic signed [cap_pkg::COORD_W-1:0] point_x;
    logic signed [cap_pkg::COORD_W-1:0] point_y;
    logic                               last;

    int mismatches;
    int outstanding;
    int requests;
    int points;
    int empty_requests;
    int clamped_requests;
    int full_circles;
    int send_idle_pct = 15;
    int recv_idle_pct = 87;
    int quiet_cycles  = 0;

    circle_arc_point_generator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_center_x   (center_x),
        .i_center_y   (center_y),
        .i_radius     (radius),
        .i_num_points (num_points),
        .i_arc_angle  (arc_angle),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_point_x    (point_x),
        .o_point_y    (point_y),
        .o_last       (last)
    );

    circle_arc_point_generator_check u_check (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_center_x         (center_x),
        .i_center_y         (center_y),
        .i_radius           (radius),
        .i_num_points       (num_points),
        .i_arc_angle        (arc_angle),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_point_x          (point_x),
        .i_point_y          (point_y),
        .i_last             (last),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding),
        .o_requests         (requests),
        .o_points           (points),
        .o_empty_requests   (empty_requests),
        .o_clamped_requests (clamped_requests),
        .o_full_circles     (full_circles)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("circle_arc_point_generator: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request beat, held until taken
    task automatic send_request(input logic signed [31:0] cx, input logic signed [31:0] cy,
                                input logic [31:0] r, input logic [6:0] n,
                                input logic [15:0] span);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        center_x   <= cx;
        center_y   <= cy;
        radius     <= r;
        num_points <= n;
        arc_angle  <= span;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return 32'sh8000_0000;
        if (sel < 10)
            return 32'sh7FFF_FFFF;
        if (sel < 60)
            return $urandom;
        return int'($urandom_range(32'h1F_FFFF)) - 32'sd1048576;
    endfunction

    initial begin
        int          sel;
        logic [31:0] r;
        logic [6:0]  n;
        logic [15:0] span;

        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;

        // corner requests
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd4, cap_pkg::FULL_SPAN);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd8, 16'd23040);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd1, 16'd11520);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd1, cap_pkg::FULL_SPAN);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd0, cap_pkg::FULL_SPAN);
        send_request(32'sh0064_0000, -32'sh0032_0000, 32'h0001_0000, 7'd127,
                     cap_pkg::FULL_SPAN);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd65, 16'd20000);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 7'd8, cap_pkg::FULL_SPAN);
        send_request(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 7'd8, cap_pkg::FULL_SPAN);
        send_request(32'sd12345, -32'sd777, 32'h0000_0000, 7'd4, cap_pkg::FULL_SPAN);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd5, 16'hFFFF);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd6, 16'd46081);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd6, 16'd46079);
        send_request(32'sd0, 32'sd0, 32'h0001_0000, 7'd2, 16'd0);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'h7FFF_FFFF, 7'd64, cap_pkg::FULL_SPAN);
        send_request(-32'sd1, 32'sd1, 32'h8000_0000, 7'd3, 16'd32768);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 15;
            end else if (i == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sel = $urandom_range(99);
            if (sel < 4)
                n = 7'd0;
            else if (sel < 10)
                n = 7'($urandom_range(127, 65));
            else if (sel < 20)
                n = 7'($urandom_range(64, 17));
            else
                n = 7'($urandom_range(16, 1));
            sel = $urandom_range(99);
            if (sel < 20)
                span = cap_pkg::FULL_SPAN;
            else if (sel < 30)
                span = 16'($urandom_range(65535, 46081));
            else if (sel < 35)
                span = 16'd0;
            else
                span = 16'($urandom_range(46079, 1));
            sel = $urandom_range(99);
            if (sel < 10)
                r = 32'hFFFF_FFFF;
            else if (sel < 15)
                r = 32'd0;
            else if (sel < 50)
                r = $urandom;
            else
                r = $urandom_range(32'h00FF_FFFF);
            send_request(pick_coord(), pick_coord(), r, n, span);
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests (%0d with no points, %0d over the point limit, %0d full circles)",
                 requests, empty_requests, clamped_requests, full_circles);
        $display("%0d point beats checked across three sender/receiver idle mixes", points);
        if (mismatches == 0 && outstanding == 0)
            $display("circle_arc_point_generator: match");
        else
            $display("circle_arc_point_generator: mismatch");
        $finish;
    end

endmodule

FILE: circle_arc_point_generator.f
rtl/core/cap_pkg.sv
rtl/core/circle_arc_point_generator.sv
sim/circle_arc_point_generator_check.sv
sim/circle_arc_point_generator_test.sv
